// ===== rtl/core/sms_pkg.sv =====
// ----------------------------------------------------------------------------
// sms_pkg
// shared constants and types for the sorted matrix staircase search block
// ----------------------------------------------------------------------------
package sms_pkg;

  localparam int unsigned SMS_MAX_ROWS    = 64;
  localparam int unsigned SMS_MAX_COLS    = 64;
  localparam int unsigned SMS_VALUE_WIDTH = 32;

  // configuration register width and reset value
  localparam int unsigned REG_W     = 7;
  localparam logic [REG_W-1:0] REG_RESET = 7'd64;

  // register index, taken from paddr[2]
  typedef enum logic {
    REG_ROWS = 1'b0,
    REG_COLS = 1'b1
  } reg_idx_t;

  // operation code of a request
  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SEARCH = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_WALK = 2'b10
  } state_t;

endpackage

// ===== rtl/core/sorted_matrix_staircase_search.sv =====
// ----------------------------------------------------------------------------
// sorted_matrix_staircase_search
// staircase search over a row- and column-sorted matrix held in a ram
// ----------------------------------------------------------------------------
// A write request stores one entry and busy stays low, so the next request
// can follow right away. A search request walks from the top-right corner
// of the region in use, one ram read per step, moving down or left. Each
// step is the read of one entry, its compare with the key and the next
// address going back to the ram's read port. The result appears on the
// out_ ports for exactly one cycle with out_valid, the cycle after the walk
// ends; it cannot be held off, so it must be taken when shown. A new
// request may be started in that same cycle. Entries must be written before
// a search reads them; the ram has no reset and no clearing pass. The user
// must write the region registers through the apb port while the block is
// idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module sorted_matrix_staircase_search
  import sms_pkg::*;
#(
  parameter int unsigned MAX_ROWS    = SMS_MAX_ROWS,
  parameter int unsigned MAX_COLS    = SMS_MAX_COLS,
  parameter int unsigned VALUE_WIDTH = SMS_VALUE_WIDTH
) (
  input  logic               clk,
  input  logic               rst_n,
  // request channel
  input  logic               start,
  output logic               busy,
  input  logic               in_operation,
  input  logic [5:0]         in_entry_row,
  input  logic [5:0]         in_entry_col,
  input  logic signed [31:0] in_entry_value,
  input  logic signed [31:0] in_search_key,
  // result channel
  output logic               out_valid,
  output logic               out_found,
  output logic [5:0]         out_hit_row,
  output logic [5:0]         out_hit_col,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int unsigned ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned DEPTH = MAX_ROWS * MAX_COLS;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // configuration registers
  logic [REG_W-1:0] rows_cfg_r, cols_cfg_r;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_cfg_r <= REG_RESET;
      cols_cfg_r <= REG_RESET;
    end else if (cfg_wr) begin
      unique case (reg_idx_t'(paddr[2]))
        REG_ROWS: rows_cfg_r <= pwdata[REG_W-1:0];
        REG_COLS: cols_cfg_r <= pwdata[REG_W-1:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_t'(paddr[2]))
      REG_ROWS: prdata = {{(32-REG_W){1'b0}}, rows_cfg_r};
      REG_COLS: prdata = {{(32-REG_W){1'b0}}, cols_cfg_r};
      default:  prdata = '0;
    endcase
  end

  // last row and last column of the region, after clamping
  logic [ROW_W-1:0] rows_last;
  logic [COL_W-1:0] cols_last;

  always_comb begin
    priority if (rows_cfg_r == '0) begin
      rows_last = '0;
    end else if (32'(rows_cfg_r) > MAX_ROWS) begin
      rows_last = ROW_W'(MAX_ROWS - 1);
    end else begin
      rows_last = ROW_W'(32'(rows_cfg_r) - 32'd1);
    end
    priority if (cols_cfg_r == '0) begin
      cols_last = '0;
    end else if (32'(cols_cfg_r) > MAX_COLS) begin
      cols_last = COL_W'(MAX_COLS - 1);
    end else begin
      cols_last = COL_W'(32'(cols_cfg_r) - 32'd1);
    end
  end

  // walk state
  state_t                  state_r, state_nxt;
  logic [ROW_W-1:0]        r_r, r_nxt;
  logic [COL_W-1:0]        c_r, c_nxt;
  logic [ROW_W-1:0]        rlast_r, rlast_nxt;
  logic signed [VALUE_WIDTH-1:0] key_r, key_nxt;
  logic                    done;
  logic                    hit;

  logic                    ovalid_r, ovalid_nxt;
  logic                    ofound_r, ofound_nxt;
  logic [5:0]              orow_r, orow_nxt;
  logic [5:0]              ocol_r, ocol_nxt;

  // ram ports
  logic                          we;
  logic [AW-1:0]                 waddr, raddr;
  logic [VALUE_WIDTH-1:0]        wdata;
  logic [VALUE_WIDTH-1:0]        rdata;
  logic signed [VALUE_WIDTH-1:0] val;

  logic accept;
  assign accept = start & ~busy;
  assign busy   = (state_r == S_WALK);
  assign val    = $signed(rdata);

  // writes land only while idle and only a walk uses the read data, so they never collide
  assign we    = accept & (op_t'(in_operation) == OP_WRITE)
                 & (32'(in_entry_row) < MAX_ROWS) & (32'(in_entry_col) < MAX_COLS);
  assign waddr = AW'(AW'(in_entry_row) * AW'(MAX_COLS)) + AW'(in_entry_col);
  assign wdata = VALUE_WIDTH'(in_entry_value);
  assign raddr = AW'(AW'(r_nxt) * AW'(MAX_COLS)) + AW'(c_nxt);

  always_comb begin
    state_nxt  = state_r;
    r_nxt      = r_r;
    c_nxt      = c_r;
    rlast_nxt  = rlast_r;
    key_nxt    = key_r;
    ovalid_nxt = 1'b0;
    ofound_nxt = ofound_r;
    orow_nxt   = orow_r;
    ocol_nxt   = ocol_r;
    hit        = 1'b0;
    done       = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept && op_t'(in_operation) == OP_SEARCH) begin
          state_nxt = S_WALK;
          r_nxt     = '0;
          c_nxt     = cols_last;
          rlast_nxt = rows_last;
          key_nxt   = VALUE_WIDTH'(in_search_key);
        end
      end
      S_WALK: begin
        // rdata holds the entry at (r_r, c_r)
        priority if (val == key_r) begin
          hit  = 1'b1;
          done = 1'b1;
        end else if (val < key_r && r_r != rlast_r) begin
          r_nxt = r_r + ROW_W'(1);
        end else if (val > key_r && c_r != '0) begin
          c_nxt = c_r - COL_W'(1);
        end else begin
          done = 1'b1;
        end
        if (done) begin
          state_nxt  = S_IDLE;
          ovalid_nxt = 1'b1;
          ofound_nxt = hit;
          orow_nxt   = 6'(r_r);
          ocol_nxt   = 6'(c_r);
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    r_r      <= r_nxt;
    c_r      <= c_nxt;
    rlast_r  <= rlast_nxt;
    key_r    <= key_nxt;
    ofound_r <= ofound_nxt;
    orow_r   <= orow_nxt;
    ocol_r   <= ocol_nxt;
  end

  sms_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign out_valid   = ovalid_r;
  assign out_found   = ofound_r;
  assign out_hit_row = orow_r;
  assign out_hit_col = ocol_r;

  // a result only shows once the walk has handed back control
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> state_r == S_IDLE)
    else $error("result shown while a walk is running");

  // every search passes through the walk state, so results never come back to back
  a_result_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("two results in consecutive cycles");

  // accepted search request always starts a walk
  a_search_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && op_t'(in_operation) == OP_SEARCH) |=> busy)
    else $error("search request did not start a walk");

  // the walk never moves below the last row in use
  a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> r_r <= rlast_r)
    else $error("walk moved below the last row in use");

  // no ram write while a walk reads
  a_no_write_walk: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !we)
    else $error("ram written during a walk");

endmodule

// ===== rtl/core/sms_ram.sv =====
// ----------------------------------------------------------------------------
// sms_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module sms_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== bench/tb_sorted_matrix_staircase_search.sv =====
// ----------------------------------------------------------------------------
// tb_sorted_matrix_staircase_search
// self-checking bench for the staircase search over a sorted matrix
// ----------------------------------------------------------------------------
// A sorted 64x64 matrix is staged in the bench; before each search the bench
// follows the walk itself and writes every entry on the path that the store
// does not hold yet, so no search touches an entry that was never written. A
// short directed part covers the corners, the longest walk, keys outside the
// value range, the extreme values, an unsorted entry and the region registers
// at zero, one, full and above full. Random phases then set a region over the
// apb port, often stage a fresh sorted matrix, and mix searches (mostly for
// keys that are in the region or next to them) with stray writes. A
// scoreboard walks its own copy of the matrix for every accepted search and
// checks each result strobe.
// ----------------------------------------------------------------------------
module tb_sorted_matrix_staircase_search;
  import sms_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ITEM_TARGET = 550;

  typedef struct {
    logic               found;
    logic [5:0]         row;
    logic [5:0]         col;
    logic signed [31:0] key;
  } walk_result_t;

  class walk_scoreboard;
    logic signed [31:0] cells [SMS_MAX_ROWS][SMS_MAX_COLS];
    logic [REG_W-1:0]   rows_reg;
    logic [REG_W-1:0]   cols_reg;
    walk_result_t       awaited_walks [$];
    int unsigned        mismatches;

    function new();
      rows_reg    = REG_RESET;
      cols_reg    = REG_RESET;
      mismatches  = 0;
    endfunction

    // zero acts as one, anything past the store acts as the full size
    static function int unsigned clamp_extent(logic [REG_W-1:0] v, int unsigned top);
      if (v == 0) return 1;
      if (v > top) return top;
      return v;
    endfunction

    function void set_region(reg_idx_t idx, logic [31:0] data);
      if (idx == REG_ROWS) rows_reg = data[REG_W-1:0];
      else cols_reg = data[REG_W-1:0];
    endfunction

    function walk_result_t staircase_walk(logic signed [31:0] key);
      walk_result_t res;
      int unsigned nr, nc, r, c;
      logic signed [31:0] v;
      nr = clamp_extent(rows_reg, SMS_MAX_ROWS);
      nc = clamp_extent(cols_reg, SMS_MAX_COLS);
      r = 0;
      c = nc - 1;
      res.found = 1'b0;
      res.key = key;
      for (int n = 0; n <= nr + nc; n++) begin
        v = cells[r][c];
        if (v == key) begin
          res.found = 1'b1;
          break;
        end else if (v < key && r + 1 < nr) begin
          r++;
        end else if (v > key && c > 0) begin
          c--;
        end else begin
          break;
        end
      end
      res.row = r[5:0];
      res.col = c[5:0];
      return res;
    endfunction

    function void note_request(op_t op, logic [5:0] row, logic [5:0] col,
                               logic signed [31:0] value, logic signed [31:0] key);
      if (op == OP_WRITE) cells[row][col] = value;
      else awaited_walks.push_back(staircase_walk(key));
    endfunction

    function int pending();
      return awaited_walks.size();
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_result(logic found, logic [5:0] row, logic [5:0] col);
      walk_result_t want;
      if (awaited_walks.size() == 0) begin
        report_mismatch($sformatf("result (found %b row %0d col %0d) with no search waiting",
                                  found, row, col));
        return;
      end
      want = awaited_walks.pop_front();
      if (found !== want.found)
        report_mismatch($sformatf("key %0d: found %b, predicted %b", want.key, found,
                                  want.found));
      if (row !== want.row)
        report_mismatch($sformatf("key %0d: row %0d, predicted %0d", want.key, row, want.row));
      if (col !== want.col)
        report_mismatch($sformatf("key %0d: col %0d, predicted %0d", want.key, col, want.col));
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic               in_operation = OP_WRITE;
  logic [5:0]         in_entry_row = '0;
  logic [5:0]         in_entry_col = '0;
  logic signed [31:0] in_entry_value = '0;
  logic signed [31:0] in_search_key = '0;
  logic               out_valid;
  logic               out_found;
  logic [5:0]         out_hit_row;
  logic [5:0]         out_hit_col;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [2:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  walk_scoreboard     sb = new();
  longint             staged [SMS_MAX_ROWS][SMS_MAX_COLS];
  // what the store holds, and which entries it holds for the staged matrix
  logic signed [31:0] shadow [SMS_MAX_ROWS][SMS_MAX_COLS];
  bit                 loaded [SMS_MAX_ROWS][SMS_MAX_COLS];
  int unsigned        region_rows = SMS_MAX_ROWS;
  int unsigned        region_cols = SMS_MAX_COLS;
  bit                 calm;
  int unsigned        request_count;

  sorted_matrix_staircase_search i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_operation   (in_operation),
    .in_entry_row   (in_entry_row),
    .in_entry_col   (in_entry_col),
    .in_entry_value (in_entry_value),
    .in_search_key  (in_search_key),
    .out_valid      (out_valid),
    .out_found      (out_found),
    .out_hit_row    (out_hit_row),
    .out_hit_col    (out_hit_col),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid === 1'b1) sb.check_result(out_found, out_hit_row, out_hit_col);
      if (start && busy === 1'b0)
        sb.note_request(op_t'(in_operation), in_entry_row, in_entry_col, in_entry_value,
                        in_search_key);
      if (psel && penable && pwrite && pready)
        sb.set_region(reg_idx_t'(paddr[2]), pwdata);
    end
  end

  // mostly back to back, sometimes a short gap, now and then a long gap
  function automatic int unsigned gap_len();
    int unsigned pick;
    if (calm) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic issue(op_t op, logic [5:0] row, logic [5:0] col,
                       logic signed [31:0] value, logic signed [31:0] key);
    int unsigned n;
    in_operation   <= op;
    in_entry_row   <= row;
    in_entry_col   <= col;
    in_entry_value <= value;
    in_search_key  <= key;
    start          <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    request_count++;
    // start stays high when the next request follows at once
    n = gap_len();
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic write_cell(int unsigned r, int unsigned c, logic signed [31:0] value);
    shadow[r][c] = value;
    loaded[r][c] = 1'b1;
    issue(OP_WRITE, 6'(r), 6'(c), value, $urandom);
  endtask

  // entry as the store will hold it when a walk reads it
  function automatic logic signed [31:0] cell_value(int unsigned r, int unsigned c);
    if (loaded[r][c]) return shadow[r][c];
    return staged[r][c][31:0];
  endfunction

  // follow the walk ahead of time and write the staged entries on its path
  task automatic preload_walk(logic signed [31:0] key);
    int unsigned r, c;
    logic signed [31:0] v;
    r = 0;
    c = region_cols - 1;
    for (int n = 0; n <= region_rows + region_cols; n++) begin
      v = cell_value(r, c);
      if (!loaded[r][c]) write_cell(r, c, v);
      if (v == key) begin
        break;
      end else if (v < key && r + 1 < region_rows) begin
        r++;
      end else if (v > key && c > 0) begin
        c--;
      end else begin
        break;
      end
    end
  endtask

  task automatic search(logic signed [31:0] key);
    preload_walk(key);
    issue(OP_SEARCH, 6'($urandom), 6'($urandom), $urandom, key);
  endtask

  // drop start, drain all results, let a trailing write land
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0 || busy !== 1'b0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_reg(reg_idx_t idx, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
  endtask

  // upper data bits are junk, only the low seven bits matter
  task automatic configure(logic [REG_W-1:0] nrows, logic [REG_W-1:0] ncols);
    settle();
    set_reg(REG_ROWS, ($urandom & 32'hFFFF_FF80) | 32'(nrows));
    set_reg(REG_COLS, ($urandom & 32'hFFFF_FF80) | 32'(ncols));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    region_rows = walk_scoreboard::clamp_extent(nrows, SMS_MAX_ROWS);
    region_cols = walk_scoreboard::clamp_extent(ncols, SMS_MAX_COLS);
  endtask

  // each entry is the larger of its upper and left neighbors plus a small step;
  // entries reach the store only when a walk is about to read them
  task automatic fill_sorted(longint base, int unsigned step_max);
    longint up, left;
    for (int r = 0; r < SMS_MAX_ROWS; r++) begin
      for (int c = 0; c < SMS_MAX_COLS; c++) begin
        up   = (r > 0) ? staged[r-1][c] : base;
        left = (c > 0) ? staged[r][c-1] : base;
        staged[r][c] = ((up > left) ? up : left) + $urandom_range(0, step_max);
        loaded[r][c] = 1'b0;
      end
    end
  endtask

  function automatic logic signed [31:0] pick_key(int unsigned nr, int unsigned nc);
    logic signed [31:0] v;
    int unsigned pick;
    v = cell_value($urandom_range(0, nr - 1), $urandom_range(0, nc - 1));
    pick = $urandom_range(0, 99);
    if (pick < 50) return v;
    if (pick < 65) return v + 1;
    if (pick < 75) return v - 1;
    if (pick < 85) return $urandom;
    if (pick < 90) return 32'sh8000_0000;
    if (pick < 95) return 32'sh7FFF_FFFF;
    return cell_value(0, 0) - 1;
  endfunction

  task automatic run_phase();
    logic [REG_W-1:0] rv, cv;
    int unsigned nr, nc, pick;
    longint base;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      rv = $urandom_range(1, 8);
      cv = $urandom_range(1, 8);
    end else if (pick < 70) begin
      rv = $urandom_range(1, 24);
      cv = $urandom_range(1, 24);
    end else if (pick < 78) begin
      rv = $urandom_range(0, 1);
      cv = $urandom_range(0, 64);
    end else if (pick < 86) begin
      rv = $urandom_range(65, 127);
      cv = $urandom_range(0, 127);
    end else if (pick < 94) begin
      rv = 64;
      cv = 64;
    end else begin
      rv = $urandom_range(1, 64);
      cv = $urandom_range(0, 1);
    end
    configure(rv, cv);
    calm = ($urandom_range(0, 3) == 0);
    nr = walk_scoreboard::clamp_extent(rv, SMS_MAX_ROWS);
    nc = walk_scoreboard::clamp_extent(cv, SMS_MAX_COLS);
    if (nr * nc <= 256 && $urandom_range(0, 4) != 0) begin
      base = longint'($urandom_range(0, 32'hFFFF_FC00)) - 64'sd2147483648;
      fill_sorted(base, $urandom_range(0, 3));
    end
    repeat ($urandom_range(15, 40)) begin
      if (request_count >= ITEM_TARGET) break;
      if ($urandom_range(0, 99) < 15)
        write_cell($urandom_range(0, 63), $urandom_range(0, 63), $urandom);
      else
        search(pick_key(nr, nc));
    end
  endtask

  initial begin
    calm = 1'b0;
    request_count = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // sorted matrix over the whole store, written lazily along each walk
    fill_sorted(longint'($urandom_range(0, 32'h7FFF_FFFF)) - 64'sd1073741824, 3);

    search(cell_value(0, 63));                // hit at the starting corner
    search(cell_value(63, 0));                // longest walk
    search(cell_value(0, 0) - 1);             // below everything: ends at column 0
    search(cell_value(63, 63) + 1);           // above everything: ends on the last row
    search(32'sh8000_0000);
    search(32'sh7FFF_FFFF);
    write_cell(0, 0, 32'sh8000_0000);
    write_cell(63, 63, 32'sh7FFF_FFFF);
    search(32'sh8000_0000);
    search(32'sh7FFF_FFFF);
    write_cell(31, 63, 32'sh8000_0000);       // breaks the ordering of the last column
    search(cell_value(40, 10));
    configure(0, 0);                          // zero region acts as one by one
    search(32'sh8000_0000);
    search(5);
    configure(127, 65);                       // oversized region acts as full
    search(cell_value(63, 0));
    configure(1, 64);
    search(cell_value(0, 17));
    search(32'sh7FFF_FFFF);
    configure(64, 1);
    search(cell_value(50, 0));
    search(32'sh7FFF_FFFF);

    while (request_count < ITEM_TARGET) run_phase();
    settle();
    repeat (8) @(posedge clk);

    if (sb.mismatches == 0)
      $display("** sorted_matrix_staircase_search: PASSED **");
    else
      $display("** sorted_matrix_staircase_search: FAILED **");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("[%0t] run did not finish in time", $realtime);
    $display("** sorted_matrix_staircase_search: FAILED **");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/sms_pkg.sv
rtl/core/sms_ram.sv
rtl/core/sorted_matrix_staircase_search.sv
bench/tb_sorted_matrix_staircase_search.sv
